@@ hw/rtl/differential_drive_odometry_core_macros.svh @@
// Assertion macros for the differential-drive odometry core.
// Included by the top level; no other dependencies.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_CORE_MACROS_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DDO_ASSERT_SAME(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("assertion failed");
`define DDO_ASSERT_NEXT(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define DDO_ASSERT_SAME(label, clk, rstn, a, b)
`define DDO_ASSERT_NEXT(label, clk, rstn, a, b)
`endif
`endif

@@ hw/rtl/ddo_pkg.sv @@
// Shared types and constants of the differential-drive odometry core.
// No dependencies.
package ddo_pkg;

    localparam int STEP_W = 5;
    localparam int WRAP_TOP = 10;
    localparam int PI_Q13 = 25736;
    localparam int TWO_PI_Q13 = 51472;
    localparam int HALF_PI_Q13 = 12868;
    localparam int WRAP_OFFSET = 52707328;
    localparam int CORDIC_GAIN = 652032874;

    localparam logic [1:0] CFG_TICK_PERIOD = 2'd0;
    localparam logic [1:0] CFG_INV_TRACK = 2'd1;
    localparam logic [1:0] CFG_USE_IMU = 2'd2;

    localparam logic [15:0] TICK_PERIOD_RST = 16'd655;
    localparam logic [15:0] INV_TRACK_RST = 16'd2560;

    typedef struct packed {
        logic              load_in;
        logic              mode_chg;
        logic              mul_a;
        logic              mul_b;
        logic              wrap_load;
        logic              wrap_step;
        logic              wrap_store;
        logic              rot_load;
        logic              rot_step;
        logic              trig;
        logic              pmul;
        logic              padd;
        logic              out_load;
        logic              sel;
        logic              axis;
        logic [STEP_W-1:0] step;
    } ddo_cmd_t;

    function automatic logic [31:0] atan_q30(input logic [STEP_W-1:0] i);
        logic [31:0] v;
        case (i)
            5'd0: v = 32'h3243F6A8;
            5'd1: v = 32'h1DAC6705;
            5'd2: v = 32'h0FADBAFC;
            5'd3: v = 32'h07F56EA6;
            5'd4: v = 32'h03FEAB76;
            5'd5: v = 32'h01FFD55B;
            5'd6: v = 32'h00FFFAAA;
            5'd7: v = 32'h007FFF55;
            5'd8: v = 32'h003FFFEA;
            5'd9: v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/ddo_ctrl.sv @@
// Sequencer of the odometry core: walks one item through the datapath.
// Depends on ddo_pkg.
module ddo_ctrl
    import ddo_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    input  logic     s_op,
    output logic     s_tready,
    input  logic     m_tready,
    output logic     m_tvalid,
    output ddo_cmd_t cmd
);

    typedef enum logic [12:0] {
        ST_IDLE      = 13'b0000000000001,
        ST_MODE      = 13'b0000000000010,
        ST_MUL_A     = 13'b0000000000100,
        ST_MUL_B     = 13'b0000000001000,
        ST_WRAP_LD   = 13'b0000000010000,
        ST_WRAP_STEP = 13'b0000000100000,
        ST_WRAP_ST   = 13'b0000001000000,
        ST_ROT_LD    = 13'b0000010000000,
        ST_ROT_STEP  = 13'b0000100000000,
        ST_TRIG      = 13'b0001000000000,
        ST_PMUL      = 13'b0010000000000,
        ST_PADD      = 13'b0100000000000,
        ST_DONE      = 13'b1000000000000
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              sel_reg, sel_next;
    logic              axis_reg, axis_next;
    logic              m_tvalid_reg, m_tvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            sel_reg      <= 1'b0;
            axis_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            sel_reg      <= sel_next;
            axis_reg     <= axis_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sel_next   = sel_reg;
        axis_next  = axis_reg;
        cmd        = '0;
        cmd.sel    = sel_reg;
        cmd.axis   = axis_reg;
        cmd.step   = cnt_reg;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = s_op ? ST_MODE : ST_MUL_A;
                end
            end
            ST_MODE: begin
                cmd.mode_chg = 1'b1;
                state_next   = ST_DONE;
            end
            ST_MUL_A: begin
                cmd.mul_a  = 1'b1;
                state_next = ST_MUL_B;
            end
            ST_MUL_B: begin
                cmd.mul_b  = 1'b1;
                sel_next   = 1'b0;
                state_next = ST_WRAP_LD;
            end
            ST_WRAP_LD: begin
                cmd.wrap_load = 1'b1;
                cnt_next      = STEP_W'(WRAP_TOP);
                state_next    = ST_WRAP_STEP;
            end
            ST_WRAP_STEP: begin
                cmd.wrap_step = 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_WRAP_ST;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_WRAP_ST: begin
                cmd.wrap_store = 1'b1;
                if (!sel_reg) begin
                    sel_next   = 1'b1;
                    state_next = ST_WRAP_LD;
                end else begin
                    sel_next   = 1'b0;
                    state_next = ST_ROT_LD;
                end
            end
            ST_ROT_LD: begin
                cmd.rot_load = 1'b1;
                cnt_next     = '0;
                state_next   = ST_ROT_STEP;
            end
            ST_ROT_STEP: begin
                cmd.rot_step = 1'b1;
                if (cnt_reg == STEP_W'(CORDIC_STEPS - 1)) begin
                    state_next = ST_TRIG;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_TRIG: begin
                cmd.trig   = 1'b1;
                axis_next  = 1'b0;
                state_next = ST_PMUL;
            end
            ST_PMUL: begin
                cmd.pmul   = 1'b1;
                state_next = ST_PADD;
            end
            ST_PADD: begin
                cmd.padd = 1'b1;
                if (!axis_reg) begin
                    axis_next  = 1'b1;
                    state_next = ST_PMUL;
                end else if (!sel_reg) begin
                    sel_next   = 1'b1;
                    state_next = ST_ROT_LD;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

@@ hw/rtl/ddo_dp.sv @@
// Datapath of the odometry core: config, speed products, heading wrap,
// CORDIC rotator, pose accumulators and result register. Depends on ddo_pkg.
module ddo_dp
    import ddo_pkg::*;
#(
    parameter int POS_WIDTH = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  ddo_cmd_t     cmd,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_wdata,
    input  logic [47:0]  s_tdata,
    output logic [159:0] m_tdata
);

    localparam int SW = ((POS_WIDTH > 25) ? POS_WIDTH : 25) + 1;
    localparam int EW = (POS_WIDTH > 32) ? POS_WIDTH : 32;

    logic [15:0]        tick_period_reg, inv_track_reg;
    logic               use_imu_reg;
    logic signed [15:0] right_reg, left_reg, imu_reg;
    logic signed [33:0] dist_reg;
    logic signed [32:0] p1_reg;
    logic signed [26:0] dh_reg;
    logic [27:0]        wv_reg;
    logic signed [15:0] pose_h_reg, seg_h_reg, latched_reg;
    logic signed [33:0] x_reg, y_reg;
    logic signed [32:0] z_reg;
    logic               neg_reg;
    logic signed [17:0] c_reg, s_reg;
    logic signed [51:0] prod_reg;
    logic signed [POS_WIDTH-1:0] acc_reg [4];
    logic [159:0]       out_reg;

    logic signed [16:0] tp_s, inv_s, sum_s, diff_s;
    logic signed [49:0] dh_prod;
    logic signed [26:0] wrap_op;
    logic signed [27:0] wrap_ld;
    logic [27:0]        wrap_mod;
    logic [16:0]        wrap_r;
    logic signed [15:0] wrap_h;
    logic signed [15:0] rot_h, fold_h;
    logic               fold_neg;
    logic signed [33:0] x_sh, y_sh;
    logic signed [32:0] atan_s;
    logic signed [17:0] c_rnd, s_rnd;
    logic signed [24:0] pstep;
    logic signed [SW-1:0] psum, sat_hi, sat_lo;
    logic [1:0]         acc_idx;

    function automatic logic [31:0] out_pos(input logic signed [POS_WIDTH-1:0] v);
        logic signed [EW-1:0] e;
        logic [31:0]          r;
        e = EW'(v);
        if (e > EW'(32'sh7FFFFFFF)) begin
            r = 32'h7FFFFFFF;
        end else if (e < EW'(-32'sh80000000)) begin
            r = 32'h80000000;
        end else begin
            r = e[31:0];
        end
        return r;
    endfunction

    assign tp_s    = signed'({1'b0, tick_period_reg});
    assign inv_s   = signed'({1'b0, inv_track_reg});
    assign sum_s   = 17'(right_reg) + 17'(left_reg);
    assign diff_s  = 17'(right_reg) - 17'(left_reg);
    assign dh_prod = 50'(p1_reg * tp_s);

    always_comb begin
        if (use_imu_reg) begin
            wrap_op = cmd.sel ? 27'(imu_reg) - 27'(latched_reg) : 27'(imu_reg);
        end else begin
            wrap_op = (cmd.sel ? 27'(seg_h_reg) : 27'(pose_h_reg)) + dh_reg;
        end
        wrap_ld  = 28'(wrap_op) + 28'(WRAP_OFFSET);
        wrap_mod = 28'(TWO_PI_Q13) << cmd.step[3:0];
        wrap_r   = wv_reg[16:0];
        if (wrap_r > 17'(PI_Q13)) begin
            wrap_h = 16'(wrap_r - 17'(TWO_PI_Q13));
        end else begin
            wrap_h = 16'(wrap_r);
        end
    end

    always_comb begin
        rot_h    = cmd.sel ? seg_h_reg : pose_h_reg;
        fold_neg = 1'b0;
        fold_h   = rot_h;
        if (rot_h > 16'(HALF_PI_Q13)) begin
            fold_h   = rot_h - 16'(PI_Q13);
            fold_neg = 1'b1;
        end else if (rot_h < -16'(HALF_PI_Q13)) begin
            fold_h   = rot_h + 16'(PI_Q13);
            fold_neg = 1'b1;
        end
        x_sh   = x_reg >>> cmd.step;
        y_sh   = y_reg >>> cmd.step;
        atan_s = signed'({1'b0, atan_q30(cmd.step)});
        c_rnd  = 18'((x_reg + 34'sd32768) >>> 16);
        s_rnd  = 18'((y_reg + 34'sd32768) >>> 16);
    end

    always_comb begin
        acc_idx = {cmd.sel, cmd.axis};
        pstep   = 25'((prod_reg + 52'sd67108864) >>> 27);
        psum    = SW'(acc_reg[acc_idx]) + SW'(pstep);
        sat_hi  = SW'({1'b0, {(POS_WIDTH-1){1'b1}}});
        sat_lo  = -sat_hi - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_period_reg <= TICK_PERIOD_RST;
            inv_track_reg   <= INV_TRACK_RST;
            use_imu_reg     <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_TICK_PERIOD: tick_period_reg <= cfg_wdata;
                CFG_INV_TRACK:   inv_track_reg   <= cfg_wdata;
                CFG_USE_IMU:     use_imu_reg     <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pose_h_reg  <= '0;
            seg_h_reg   <= '0;
            latched_reg <= '0;
            for (int i = 0; i < 4; i++) begin
                acc_reg[i] <= '0;
            end
        end else begin
            if (cmd.mode_chg) begin
                latched_reg <= imu_reg;
                seg_h_reg   <= '0;
                acc_reg[2]  <= '0;
                acc_reg[3]  <= '0;
            end
            if (cmd.wrap_store) begin
                if (cmd.sel) begin
                    seg_h_reg <= wrap_h;
                end else begin
                    pose_h_reg <= wrap_h;
                end
            end
            if (cmd.padd) begin
                if (psum > sat_hi) begin
                    acc_reg[acc_idx] <= sat_hi[POS_WIDTH-1:0];
                end else if (psum < sat_lo) begin
                    acc_reg[acc_idx] <= sat_lo[POS_WIDTH-1:0];
                end else begin
                    acc_reg[acc_idx] <= psum[POS_WIDTH-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            right_reg <= s_tdata[15:0];
            left_reg  <= s_tdata[31:16];
            imu_reg   <= s_tdata[47:32];
        end
        if (cmd.mul_a) begin
            dist_reg <= 34'(sum_s * tp_s);
            p1_reg   <= 33'(diff_s * inv_s);
        end
        if (cmd.mul_b) begin
            dh_reg <= 27'((dh_prod + 50'sd4194304) >>> 23);
        end
        if (cmd.wrap_load) begin
            wv_reg <= unsigned'(wrap_ld);
        end else if (cmd.wrap_step && wv_reg >= wrap_mod) begin
            wv_reg <= wv_reg - wrap_mod;
        end
        if (cmd.rot_load) begin
            x_reg   <= 34'(CORDIC_GAIN);
            y_reg   <= '0;
            z_reg   <= 33'(fold_h) <<< 17;
            neg_reg <= fold_neg;
        end else if (cmd.rot_step) begin
            if (z_reg >= 0) begin
                x_reg <= x_reg - y_sh;
                y_reg <= y_reg + x_sh;
                z_reg <= z_reg - atan_s;
            end else begin
                x_reg <= x_reg + y_sh;
                y_reg <= y_reg - x_sh;
                z_reg <= z_reg + atan_s;
            end
        end
        if (cmd.trig) begin
            c_reg <= neg_reg ? -c_rnd : c_rnd;
            s_reg <= neg_reg ? -s_rnd : s_rnd;
        end
        if (cmd.pmul) begin
            prod_reg <= 52'(dist_reg * (cmd.axis ? s_reg : c_reg));
        end
        if (cmd.out_load) begin
            out_reg <= {seg_h_reg, out_pos(acc_reg[3]), out_pos(acc_reg[2]),
                        pose_h_reg, out_pos(acc_reg[1]), out_pos(acc_reg[0])};
        end
    end

    assign m_tdata = out_reg;

endmodule

@@ hw/rtl/differential_drive_odometry_core.sv @@
// Top level of the differential-drive dead-reckoning odometry core.
// Depends on ddo_pkg, ddo_ctrl, ddo_dp and the assertion macro header.
//
// channel  | direction | payload
// s_       | in        | tuser: op; tdata: right_speed, left_speed, imu_heading
// m_       | out       | tdata: global x/y/heading, segment x/y/heading
// cfg_     | in        | cfg_index selects tick_period, inv_double_track, use_imu_yaw
//
// A tick makes two 11-step heading wrap passes and two passes through the CORDIC rotator
// before its result is loaded; a mode change goes from accept through the mode-change
// state to the result load. After the load the sequencer is idle again. One item is in
// work at a time; s_tready is high only when the sequencer is idle. A result waiting in
// the output register does not block the next accept; it blocks only the next result.
// Reset is synchronous.
`include "differential_drive_odometry_core_macros.svh"
module differential_drive_odometry_core
    import ddo_pkg::*;
#(
    parameter int CORDIC_STEPS = 16,
    parameter int POS_WIDTH = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // right_speed, left_speed, imu_heading
    input  logic         s_tuser,   // op
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [159:0] m_tdata,   // global_x, global_y, global_heading,
                                    // segment_x, segment_y, segment_heading
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_wdata
);

    ddo_cmd_t cmd;

    ddo_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_op    (s_tuser),
        .s_tready(s_tready),
        .m_tready(m_tready),
        .m_tvalid(m_tvalid),
        .cmd     (cmd)
    );

    ddo_dp #(
        .POS_WIDTH(POS_WIDTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tdata  (s_tdata),
        .m_tdata  (m_tdata)
    );

    `DDO_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `DDO_ASSERT_SAME(a_result_frees_ctrl, aclk, aresetn, $rose(m_tvalid), s_tready)

endmodule

@@ dv/differential_drive_odometry_core_tb.sv @@
// Self-checking testbench for differential_drive_odometry_core: random and directed
// odometry ticks and mode changes, checked against a scoreboard that predicts the poses.
// Depends on ddo_pkg and the core RTL.
module differential_drive_odometry_core_tb;
    import ddo_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam bit OP_TICK = 1'b0;
    localparam bit OP_MODE = 1'b1;

    class odometry_scoreboard;
        longint gx, gy, sx, sy;
        int gh, sh, latched;
        bit [15:0] tick_period, inv_track;
        bit imu_mode;
        bit [159:0] pose_queue[$];
        int errors, results, ticks, mode_changes;
        longint atan_tab[16] = '{
            64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
            64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
            64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
            64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF};

        function new();
            tick_period = TICK_PERIOD_RST;
            inv_track = INV_TRACK_RST;
            imu_mode = 0;
            gx = 0; gy = 0; sx = 0; sy = 0;
            gh = 0; sh = 0; latched = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                CFG_TICK_PERIOD: tick_period = val;
                CFG_INV_TRACK: inv_track = val;
                CFG_USE_IMU: imu_mode = val[0];
                default: ;
            endcase
        endfunction

        function longint round_sh(longint v, int n);
            return (v + (64'sd1 <<< (n - 1))) >>> n;
        endfunction

        function int wrap_pi(longint a);
            longint r;
            r = a % TWO_PI_Q13;
            if (r < 0) r += TWO_PI_Q13;
            if (r > PI_Q13) r -= TWO_PI_Q13;
            return int'(r);
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function void rotate(int ang, output longint c, output longint s);
            bit flip;
            longint x, y, z, xn;
            flip = 0;
            if (ang > HALF_PI_Q13) begin
                ang -= PI_Q13; flip = 1;
            end else if (ang < -HALF_PI_Q13) begin
                ang += PI_Q13; flip = 1;
            end
            x = CORDIC_GAIN;
            y = 0;
            z = longint'(ang) * 131072;
            for (int i = 0; i < 16; i++) begin
                if (z >= 0) begin
                    xn = x - (y >>> i); y = y + (x >>> i); z -= atan_tab[i];
                end else begin
                    xn = x + (y >>> i); y = y - (x >>> i); z += atan_tab[i];
                end
                x = xn;
            end
            c = round_sh(x, 16);
            s = round_sh(y, 16);
            if (flip) begin
                c = -c; s = -s;
            end
        endfunction

        function void move(ref longint px, ref longint py, input int hd, input longint travel);
            longint c, s;
            rotate(hd, c, s);
            px = clamp32(px + round_sh(travel * c, 27));
            py = clamp32(py + round_sh(travel * s, 27));
        endfunction

        function void note_beat(bit op, logic signed [15:0] r, logic signed [15:0] l,
                                logic signed [15:0] imu);
            longint travel, dh;
            logic [31:0] ox, oy, qx, qy;
            logic [15:0] oh, qh;
            if (op == OP_MODE) begin
                latched = imu;
                sx = 0; sy = 0; sh = 0;
                mode_changes++;
            end else begin
                travel = (longint'(r) + longint'(l)) * longint'(tick_period);
                if (imu_mode) begin
                    gh = wrap_pi(imu);
                    sh = wrap_pi(longint'(imu) - latched);
                end else begin
                    dh = round_sh((longint'(r) - longint'(l)) * longint'(inv_track)
                                  * longint'(tick_period), 23);
                    gh = wrap_pi(gh + dh);
                    sh = wrap_pi(sh + dh);
                end
                move(gx, gy, gh, travel);
                move(sx, sy, sh, travel);
                ticks++;
            end
            ox = 32'(gx); oy = 32'(gy); oh = 16'(gh);
            qx = 32'(sx); qy = 32'(sy); qh = 16'(sh);
            pose_queue.push_back({qh, qy, qx, oh, oy, ox});
        endfunction

        function void check_beat(bit [159:0] got);
            bit [159:0] exp_pose;
            int offs[6] = '{0, 32, 64, 80, 112, 144};
            int wid[6] = '{32, 32, 16, 32, 32, 16};
            string names[6] = '{"global_x", "global_y", "global_heading",
                                "segment_x", "segment_y", "segment_heading"};
            bit [31:0] e, a, m;
            bit bad;
            results++;
            if (pose_queue.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat %h", got);
                return;
            end
            exp_pose = pose_queue.pop_front();
            bad = 0;
            for (int k = 0; k < 6; k++) begin
                m = (wid[k] == 32) ? 32'hFFFF_FFFF : 32'h0000_FFFF;
                e = 32'(exp_pose >> offs[k]) & m;
                a = 32'(got >> offs[k]) & m;
                if (e != a) begin
                    if (!bad) errors++;
                    bad = 1;
                    if (errors <= 10)
                        $display("result %0d %s: expected %h, got %h", results, names[k], e, a);
                end
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [47:0] s_tdata = '0;
    logic s_tuser = 0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [159:0] m_tdata;
    logic cfg_wr_en = 0;
    logic [1:0] cfg_index = '0;
    logic [15:0] cfg_wdata = '0;

    odometry_scoreboard sb = new();
    int idle_mode = 0;
    int hold_cycles = 0;
    int sent = 0;

    differential_drive_odometry_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_beat(s_tuser, s_tdata[15:0], s_tdata[31:16], s_tdata[47:32]);
        if (aresetn && m_tvalid && m_tready)
            sb.check_beat(m_tdata);
    end

    // receiver: random stall, always ready, or long hold-off
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            m_tready = 0;
        end else begin
            case (idle_mode)
                0: m_tready = ($urandom_range(99) >= 76);
                1: m_tready = ($urandom_range(99) >= 36);
                default: m_tready = 1;
            endcase
        end
    end

    task automatic send_beat(bit op, logic [15:0] r, logic [15:0] l, logic [15:0] imu);
        int pct;
        pct = (idle_mode == 0) ? 36 : (idle_mode == 1) ? 76 : 0;
        @(negedge aclk);
        while ($urandom_range(99) < pct) begin
            s_tvalid = 0;
            @(negedge aclk);
        end
        s_tvalid = 1;
        s_tuser = op;
        s_tdata = {imu, l, r};
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    task automatic release_input();
        @(negedge aclk);
        s_tvalid = 0;
    endtask

    task automatic drain();
        release_input();
        while (sb.pose_queue.size() != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge aclk);
        cfg_wr_en = 1;
        cfg_index = idx;
        cfg_wdata = val;
        sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_wr_en = 0;
    endtask

    task automatic set_config(logic [15:0] tp, logic [15:0] it, bit imu);
        drain();
        write_reg(CFG_TICK_PERIOD, tp);
        write_reg(CFG_INV_TRACK, it);
        write_reg(CFG_USE_IMU, {15'd0, imu});
    endtask

    task automatic random_beats(int n);
        bit op;
        logic [15:0] r, l, imu;
        for (int i = 0; i < n; i++) begin
            op = ($urandom_range(15) == 0) ? OP_MODE : OP_TICK;
            if ($urandom_range(3) == 0) begin
                r = 16'($urandom); l = 16'($urandom);
            end else begin
                r = 16'(int'($urandom_range(8191)) - 4096);
                l = 16'(int'(r) + int'($urandom_range(1023)) - 512);
            end
            imu = ($urandom_range(19) == 0) ? 16'($urandom)
                                             : 16'(int'($urandom_range(51472)) - 25736);
            send_beat(op, r, l, imu);
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        idle_mode = 0;
        send_beat(OP_TICK, 16'h0000, 16'h0000, 16'h0000);
        send_beat(OP_TICK, 16'h7FFF, 16'h7FFF, 16'h0000);
        send_beat(OP_TICK, 16'h8000, 16'h8000, 16'h0000);
        send_beat(OP_TICK, 16'h7FFF, 16'h8000, 16'h0000);
        send_beat(OP_TICK, 16'h8000, 16'h7FFF, 16'h0000);
        send_beat(OP_TICK, 16'h7FFF, 16'h8000, 16'h0000);
        send_beat(OP_MODE, 16'h1234, 16'h4321, 16'd25736);
        send_beat(OP_TICK, 16'h1000, 16'h0800, 16'h0000);
        send_beat(OP_MODE, 16'h0000, 16'h0000, -16'sd25736);
        send_beat(OP_TICK, 16'hF000, 16'h1000, 16'h0000);
        set_config(16'hFFFF, 16'hFFFF, 1);
        write_reg(CFG_UNUSED, 16'hFFFF);
        send_beat(OP_TICK, 16'h7FFF, 16'h7FFF, 16'd25736);
        send_beat(OP_TICK, 16'h7FFF, 16'h7FFF, -16'sd25736);
        send_beat(OP_TICK, 16'h0100, 16'h0100, 16'h7FFF);
        send_beat(OP_TICK, 16'h0100, 16'h0100, 16'h8000);
        send_beat(OP_MODE, 16'h0000, 16'h0000, 16'd20000);
        send_beat(OP_TICK, 16'h0100, 16'h0200, -16'sd20000);
        send_beat(OP_TICK, 16'h0100, 16'h0200, 16'd12868);
        send_beat(OP_TICK, 16'h0100, 16'h0200, -16'sd12869);
        set_config(16'hFFFF, 16'hFFFF, 0);
        send_beat(OP_TICK, 16'h0010, 16'h0000, 16'h0000);
        send_beat(OP_TICK, 16'h7FFF, 16'h8000, 16'h0000);

        set_config(16'd655, 16'd2560, 0);
        random_beats(160);
        set_config(16'd0, 16'd0, 0);
        random_beats(110);
        set_config(16'($urandom), 16'($urandom), 1);
        random_beats(80);
        idle_mode = 1;
        random_beats(100);
        set_config(16'd4096, 16'd65535, 0);
        random_beats(160);
        set_config(16'd300, 16'($urandom), 1);
        random_beats(110);
        idle_mode = 2;
        hold_cycles = 400;
        random_beats(140);
        set_config(16'($urandom), 16'd100, 0);
        random_beats(150);

        // drive straight ahead, then in reverse with small IMU headings, at full speed with the largest position steps
        set_config(16'hFFFF, 16'd0, 1);
        send_beat(OP_MODE, 16'h0000, 16'h0000, 16'h0000);
        for (int i = 0; i < 40; i++)
            send_beat(OP_TICK, 16'h7FFF, 16'h7FFF, 16'h0000);
        for (int i = 0; i < 20; i++)
            send_beat(OP_TICK, 16'h8000, 16'h8000, 16'($urandom_range(2000)));

        drain();
        $display("covered %0d beats: %0d ticks, %0d mode changes, %0d results checked",
                 sent, sb.ticks, sb.mode_changes, sb.results);
        $display("configs swept through tick period and track extremes, both heading sources");
        if (sb.errors == 0 && sb.pose_queue.size() == 0) begin
            $display("differential_drive_odometry_core_tb: done, clean");
        end else begin
            $display("mismatches: %0d, results still expected: %0d",
                     sb.errors, sb.pose_queue.size());
            $display("differential_drive_odometry_core_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("timeout with %0d results still expected", sb.pose_queue.size());
        $display("differential_drive_odometry_core_tb: done, errors");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/ddo_pkg.sv
hw/rtl/ddo_ctrl.sv
hw/rtl/ddo_dp.sv
hw/rtl/differential_drive_odometry_core.sv
dv/differential_drive_odometry_core_tb.sv
